@@ design/tccs_pkg.sv @@
// Package for the text console: geometry, field widths, codes and the
// controller/datapath command and status types. No dependencies.
`default_nettype none

package tccs_pkg;

  // Screen geometry.
  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int CELL_COUNT    = ROWS * COLUMNS;
  localparam int LAST_ROW_BASE = COLUMNS * (ROWS - 1);

  // Field and register widths.
  localparam int MODE_W   = 3;
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 12;
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = 16;
  localparam int ATTR_W   = 8;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;

  // Derived widths for addressing and the walk counter.
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int WALK_W = $clog2(CELL_COUNT + 1);
  localparam int LIN_W  = COL_W + ROW_W;

  // Scaled reciprocal of the row length. With the shift at least
  // log2(CELL_COUNT * COLUMNS), the product gives the exact row for every
  // position on the screen.
  localparam int RECIP_SHIFT = $clog2(CELL_COUNT * COLUMNS);
  localparam int ROW_RECIP   = (2 ** RECIP_SHIFT + COLUMNS - 1) / COLUMNS;
  localparam int PROD_W      = POS_W + RECIP_SHIFT;

  // Character and cell constants.
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;

  // Item operations.
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH       = 3'd0,
    MODE_SET_CURSOR = 3'd1,
    MODE_WRITE      = 3'd2,
    MODE_CLEAR      = 3'd3,
    MODE_READ       = 3'd4
  } mode_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic walk_clear;
    logic scroll_step;
    logic fill_step;
    logic fill_init;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              needs_scroll;
    logic              scroll_last;
    logic              fill_last;
  } sts_t;

endpackage

`default_nettype wire

@@ design/tccs_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the screen store.
`default_nettype none

module tccs_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/tccs_ctrl.sv @@
// Controller state machine of the text console: sequences each item and the
// store walks. Depends on tccs_pkg.
`default_nettype none

module tccs_ctrl import tccs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (sts_i.fill_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts_i.mode)
          MODE_PUSH:  state_d = sts_i.needs_scroll ? ST_SCROLL : ST_DONE;
          MODE_CLEAR: state_d = ST_FILL;
          default:    state_d = ST_DONE;
        endcase
      end
      ST_SCROLL: begin
        if (sts_i.scroll_last) begin
          state_d = ST_DONE;
        end
      end
      ST_FILL: begin
        if (sts_i.fill_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = in_valid_i ? ST_EXEC : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.fill_step = 1'b1;
        cmd_o.fill_init = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.exec       = 1'b1;
        cmd_o.walk_clear = 1'b1;
      end
      ST_SCROLL: begin
        cmd_o.scroll_step = 1'b1;
      end
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          in_ready_o     = 1'b1;
          cmd_o.capture  = in_valid_i;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Result valid flag.
  assign out_valid_d = cmd_o.load_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while full");

  // An accepted item is executed in the next cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_EXEC))
    else $error("accepted item not executed");

  // The scroll walk ends in the result state.
  a_scroll_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCROLL && sts_i.scroll_last) |=> (state_q == ST_DONE))
    else $error("scroll walk did not finish");

endmodule

`default_nettype wire

@@ design/tccs_datapath.sv @@
// Datapath of the text console: item and cursor registers, row reciprocal,
// store walk counter, screen RAM and result register. Depends on tccs_pkg
// and tccs_ram.
`default_nettype none

module tccs_datapath import tccs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [POS_W-1:0]    position_i,
  input  logic                cfg_we_i,
  input  logic [ATTR_W-1:0]   cfg_data_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic [CURSOR_W-1:0] cursor_position_o,
  output logic [CELL_W-1:0]   cell_word_o,
  output logic                rejected_o
);

  logic [MODE_W-1:0]   mode_q;
  logic [CHAR_W-1:0]   char_q;
  logic [POS_W-1:0]    pos_q;
  logic [ATTR_W-1:0]   attr_q;
  logic [COL_W-1:0]    col_q;
  logic [ROW_W-1:0]    row_q;
  logic [WALK_W-1:0]   walk_q;
  logic [ROW_W-1:0]    quo_q;
  logic [CURSOR_W-1:0] cursor_q;
  logic [CELL_W-1:0]   cell_q;
  logic                rej_q;

  logic                in_range;
  logic [LIN_W-1:0]    lin;
  logic                is_nl;
  logic                wrap;
  logic [COL_W:0]      col_inc;
  logic [ROW_W:0]      row_adv;
  logic                row_over;
  logic [COL_W-1:0]    push_col;
  logic [ROW_W-1:0]    push_row;
  logic [PROD_W-1:0]   recip_prod;
  logic [POS_W-1:0]    set_base;
  logic [POS_W-1:0]    set_rem;
  logic [COL_W-1:0]    set_col;
  logic [WALK_W-1:0]   walk_prev;
  logic [WALK_W-1:0]   scroll_src;
  logic [CELL_W-1:0]   blank;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;

  // Item registers, loaded when an item is accepted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      char_q <= char_code_i;
      pos_q  <= position_i;
    end
  end

  // Attribute register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_q <= cfg_data_i;
    end
  end

  assign in_range = pos_q < POS_W'(CELL_COUNT);
  assign blank    = {attr_q, SPACE_CODE};

  // Linear cursor index.
  assign lin = LIN_W'(row_q) * LIN_W'(COLUMNS) + LIN_W'(col_q);

  // Cursor advance for a pushed character, with newline and wrap.
  assign is_nl    = char_q == NEWLINE_CODE;
  assign col_inc  = {1'b0, col_q} + (COL_W + 1)'(1);
  assign wrap     = !is_nl && (col_inc >= (COL_W + 1)'(COLUMNS));
  assign row_adv  = {1'b0, row_q} + (ROW_W + 1)'(is_nl || wrap);
  assign row_over = row_adv >= (ROW_W + 1)'(ROWS);
  assign push_col = (is_nl || wrap) ? '0 : col_inc[COL_W-1:0];
  assign push_row = row_over ? ROW_W'(ROWS - 1) : row_adv[ROW_W-1:0];

  // Row of the position by reciprocal multiplication, registered when the
  // item is accepted; the column is what remains of the position.
  assign recip_prod = PROD_W'(position_i) * PROD_W'(ROW_RECIP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      quo_q <= recip_prod[RECIP_SHIFT +: ROW_W];
    end
  end

  assign set_base = POS_W'(quo_q) * POS_W'(COLUMNS);
  assign set_rem  = pos_q - set_base;
  assign set_col  = set_rem[COL_W-1:0];

  // Cursor registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.exec && (mode_q == MODE_PUSH)) begin
      col_q <= push_col;
      row_q <= push_row;
    end else if (cmd_i.exec && (mode_q == MODE_CLEAR)) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.exec && (mode_q == MODE_SET_CURSOR) && in_range) begin
      col_q <= set_col;
      row_q <= quo_q;
    end
  end

  // Walk counter for scroll and fill passes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= '0;
    end else if (cmd_i.walk_clear) begin
      walk_q <= '0;
    end else if (cmd_i.scroll_step || cmd_i.fill_step) begin
      walk_q <= walk_q + WALK_W'(1);
    end
  end

  assign walk_prev  = walk_q - WALK_W'(1);
  assign scroll_src = walk_q + WALK_W'(COLUMNS);

  // Store access. A scroll reads one row ahead and writes the cell before,
  // blanking the last row.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (cmd_i.exec) begin
      if ((mode_q == MODE_PUSH) && !is_nl) begin
        ram_we    = 1'b1;
        ram_waddr = lin[ADDR_W-1:0];
        ram_wdata = {attr_q, char_q};
      end
      if ((mode_q == MODE_WRITE) && in_range) begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[ADDR_W-1:0];
        ram_wdata = {attr_q, char_q};
      end
      if ((mode_q == MODE_READ) && in_range) begin
        ram_re    = 1'b1;
        ram_raddr = pos_q[ADDR_W-1:0];
      end
    end else if (cmd_i.scroll_step) begin
      ram_re    = walk_q < WALK_W'(LAST_ROW_BASE);
      ram_raddr = scroll_src[ADDR_W-1:0];
      ram_we    = walk_q != '0;
      ram_waddr = walk_prev[ADDR_W-1:0];
      ram_wdata = (walk_prev < WALK_W'(LAST_ROW_BASE)) ? ram_rdata : blank;
    end else if (cmd_i.fill_step) begin
      ram_we    = 1'b1;
      ram_waddr = walk_q[ADDR_W-1:0];
      ram_wdata = cmd_i.fill_init ? BLANK_CELL : blank;
    end
  end

  tccs_ram #(
    .DATA_W (CELL_W),
    .DEPTH  (CELL_COUNT)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      cursor_q <= lin[CURSOR_W-1:0];
      cell_q   <= ((mode_q == MODE_READ) && in_range) ? ram_rdata : '0;
      rej_q    <= ((mode_q == MODE_SET_CURSOR) || (mode_q == MODE_WRITE) ||
                   (mode_q == MODE_READ)) && !in_range;
    end
  end

  assign cursor_position_o = cursor_q;
  assign cell_word_o       = cell_q;
  assign rejected_o        = rej_q;

  // Status to the controller.
  assign sts_o.mode         = mode_q;
  assign sts_o.needs_scroll = (mode_q == MODE_PUSH) && row_over;
  assign sts_o.scroll_last  = walk_q == WALK_W'(CELL_COUNT);
  assign sts_o.fill_last    = walk_q == WALK_W'(CELL_COUNT - 1);

  // The cursor always points inside the screen.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q < ROW_W'(ROWS)) && (col_q < COL_W'(COLUMNS)))
    else $error("cursor outside the screen");

  // Every store write lands inside the screen.
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ({1'b0, ram_waddr} < (ADDR_W + 1)'(CELL_COUNT)))
    else $error("store write outside the screen");

  // A cursor set from a valid position leaves a column inside the row.
  a_set_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && (mode_q == MODE_SET_CURSOR) && in_range) |->
      (set_rem < POS_W'(COLUMNS)))
    else $error("cursor column outside the row");

endmodule

`default_nettype wire

@@ design/text_console_cursor_scroll_top.sv @@
// Top level of the text console: joins the controller and the datapath.
// Depends on tccs_pkg, tccs_ctrl and tccs_datapath.
//
//   Channel  Direction  Handshake                Payload
//   input    in         in_valid_i / in_ready_o  mode_i, char_code_i, position_i
//   result   out        out_valid_o/out_ready_i  cursor_position_o, cell_word_o,
//                                                rejected_o
//   config   in         cfg_valid_i/cfg_ready_o  text_attribute_i
//
// Plain pushes, cursor sets, cell writes, reads and unknown modes go from the
// execute state to the result state; the cursor row comes from a reciprocal
// multiply at acceptance. A push that scrolls adds a scroll walk and a clear a
// fill walk: the store is walked one cell a cycle through its single write port.
// After reset the store is blanked with in_ready_o low; configuration writes
// are taken at any time.
// A result waits in the output register; the next item runs meanwhile and
// holds in its last state until that register frees.
`default_nettype none

module text_console_cursor_scroll_top import tccs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [POS_W-1:0]    position_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CURSOR_W-1:0] cursor_position_o,
  output logic [CELL_W-1:0]   cell_word_o,
  output logic                rejected_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [ATTR_W-1:0]   text_attribute_i
);

  cmd_t cmd;
  sts_t sts;

  // The attribute register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  tccs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tccs_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .mode_i            (mode_i),
    .char_code_i       (char_code_i),
    .position_i        (position_i),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_data_i        (text_attribute_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cursor_position_o (cursor_position_o),
    .cell_word_o       (cell_word_o),
    .rejected_o        (rejected_o)
  );

endmodule

`default_nettype wire
